FILE: rtl/chunked_byte_ring_buffer_unit_defines.svh
// Assertion macros shared by the ring buffer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CHUNKED_BYTE_RING_BUFFER_UNIT_DEFINES_SVH
`define CHUNKED_BYTE_RING_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define CBRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated off during reset.
`define CBRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cbrb_pkg.sv
// Shared types and constants of the chunked byte ring buffer.
// No dependencies; imported by every module of the block.
package cbrb_pkg;

	localparam int DEPTH   = 1024;
	localparam int MAX_GET = 64;

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int SIZE_W = 11;
	localparam int LEN_W  = 10;
	localparam int FREE_W = 10;
	localparam int REM_W  = $clog2(MAX_GET + 1);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] STATUS_OK  = 2'd0;
	localparam logic [1:0] STATUS_OVF = 2'd1;
	localparam logic [1:0] STATUS_UNF = 2'd2;

	typedef enum logic [1:0] {
		OP_PUT     = 2'd0,
		OP_GET     = 2'd1,
		OP_GET_ERR = 2'd2
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	typedef struct packed {
		logic              clear;
		logic [SIZE_W-1:0] size;
	} ctrl_t;

endpackage

FILE: rtl/chunked_byte_ring_buffer_unit.sv
// Order: a closing put byte is queued, then answered through the result register; a get
//   is queued, then streamed from the byte store one byte per cycle unless out_ready stalls.
// Throughput: one put byte per cycle while no get streams and no result stall holds the queue;
//   set by the single write port of the byte store and the one-command-per-cycle back end.
// Reset (arst_n low): ring empty, no open chunk, sticky flag clear, buffer_size = 1024.
//   Byte store contents are undefined until written.
// Depends on cbrb_pkg, cbrb_front and cbrb_back.
module chunked_byte_ring_buffer_unit
	import cbrb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [1:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input items
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [7:0]        data_in,
	input  logic [LEN_W-1:0]  chunk_length,
	input  logic              last_of_chunk,
	// result items
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        data_out,
	output logic [1:0]        status,
	output logic              answers_get,
	output logic              last,
	output logic [FREE_W-1:0] free_space,
	output logic              overflow_sticky
);

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] size_eff;
	logic              cfg_wr;
	logic              clear_q;
	ctrl_t             ctrl;
	head_t             head;
	logic              pop;

	// Single register: buffer_size at byte offset 0. Every word offset in
	// the 2-bit address space lands on it.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == paddr[1:0]);
	assign prdata = {{(32 - SIZE_W){1'b0}}, size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_W'(DEPTH);
			clear_q <= 1'b0;
		end else begin
			// clear pulse reaches the back end together with the new size
			clear_q <= cfg_wr;
			if (cfg_wr) begin
				size_q <= pwdata[SIZE_W-1:0];
			end
		end
	end

	// buffer size is held to 2..DEPTH, so 1..DEPTH-1 bytes can be in use
	always_comb begin
		if (size_q < SIZE_W'(2)) begin
			size_eff = SIZE_W'(2);
		end else if (size_q > SIZE_W'(DEPTH)) begin
			size_eff = SIZE_W'(DEPTH);
		end else begin
			size_eff = size_q;
		end
	end

	assign ctrl.clear = clear_q;
	assign ctrl.size  = size_eff;

	// front: takes items, folds out zero-length gets, flags oversize gets
	cbrb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.data_in       (data_in),
		.chunk_length  (chunk_length),
		.last_of_chunk (last_of_chunk),
		.head          (head),
		.pop           (pop)
	);

	// back: space checks, byte store, get streaming, result register
	cbrb_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.head            (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.data_out        (data_out),
		.status          (status),
		.answers_get     (answers_get),
		.last            (last),
		.free_space      (free_space),
		.overflow_sticky (overflow_sticky)
	);

endmodule

FILE: rtl/cbrb_front.sv
// Front end: accepts input items, classifies them and queues commands.
// Depends on cbrb_pkg.
module cbrb_front
	import cbrb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  logic [7:0]       data_in,
	input  logic [LEN_W-1:0] chunk_length,
	input  logic             last_of_chunk,
	output head_t            head,
	input  logic             pop
);

	cmd_t              queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              cmd;
	logic              accept;
	logic              push;
	logic              do_pop;

	always_comb begin
		cmd.data = data_in;
		cmd.len  = chunk_length;
		cmd.last = last_of_chunk;
		if (!kind) begin
			cmd.op = OP_PUT;
		end else if (chunk_length > LEN_W'(MAX_GET)) begin
			cmd.op = OP_GET_ERR;
		end else begin
			cmd.op = OP_GET;
		end
	end

	assign in_ready = (count_q != QCNT_W'(QDEPTH));
	assign accept   = in_valid && in_ready;
	// a get of zero bytes has no effect at all
	assign push     = accept && !(kind && (chunk_length == '0));
	assign do_pop   = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.cmd   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/cbrb_back.sv
// Back end: byte store, ring indices, chunk tracking and the result register.
// Depends on cbrb_pkg; fed by cbrb_front.
module cbrb_back
	import cbrb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	input  head_t             head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        data_out,
	output logic [1:0]        status,
	output logic              answers_get,
	output logic              last,
	output logic [FREE_W-1:0] free_space,
	output logic              overflow_sticky
);

	typedef enum logic [1:0] {
		ST_CMD    = 2'b01,
		ST_STREAM = 2'b10
	} state_t;

	state_t            state_q, state_d;
	logic [7:0]        byte_store_q [DEPTH];
	logic [7:0]        rdata_q;
	logic [IDX_W-1:0]  wr_q, wr_d;
	logic [IDX_W-1:0]  rd_q, rd_d;
	logic [IDX_W-1:0]  used_q, used_d;
	logic              inside_q, inside_d;
	logic              drop_q, drop_d;
	logic              ovf_q, ovf_d;
	logic [REM_W-1:0]  rem_q, rem_d;

	logic              out_valid_q;
	logic              out_data_q;
	logic [1:0]        out_status_q;
	logic              out_get_q;
	logic              out_last_q;
	logic [FREE_W-1:0] out_free_q;
	logic              out_ovf_q;

	logic              can_emit;
	logic              emit;
	logic              emit_data;
	logic [1:0]        e_status;
	logic              e_get;
	logic              e_last;
	logic [SIZE_W-1:0] e_free;
	logic              wr_en;
	logic              rd_en;

	logic [SIZE_W-1:0] free;
	logic [SIZE_W-1:0] need;
	logic              start_drop;
	logic              drop0;
	logic              full;
	logic              drop1;
	logic [SIZE_W-1:0] wr_inc;
	logic [SIZE_W-1:0] rd_inc;

	assign can_emit = !out_valid_q || out_ready;
	assign free     = ctrl.size - SIZE_W'(1) - SIZE_W'(used_q);
	assign need     = (head.cmd.len == '0) ? SIZE_W'(1) : SIZE_W'(head.cmd.len);
	assign start_drop = need > free;
	assign drop0    = inside_q ? drop_q : start_drop;
	assign full     = (free == '0);
	assign drop1    = drop0 || full;
	assign wr_inc   = SIZE_W'(wr_q) + SIZE_W'(1);
	assign rd_inc   = SIZE_W'(rd_q) + SIZE_W'(1);

	always_comb begin
		state_d   = state_q;
		wr_d      = wr_q;
		rd_d      = rd_q;
		used_d    = used_q;
		inside_d  = inside_q;
		drop_d    = drop_q;
		ovf_d     = ovf_q;
		rem_d     = rem_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_data = 1'b0;
		e_status  = STATUS_OK;
		e_get     = 1'b0;
		e_last    = 1'b1;
		e_free    = free;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		case (state_q)
			ST_CMD: begin
				if (head.valid) begin
					case (head.cmd.op)
						OP_PUT: begin
							if (!head.cmd.last || can_emit) begin
								pop   = 1'b1;
								ovf_d = ovf_q || drop1;
								if (!drop1) begin
									wr_en  = 1'b1;
									wr_d   = (wr_inc == ctrl.size) ? '0 : IDX_W'(wr_inc);
									used_d = used_q + 1'b1;
									e_free = free - SIZE_W'(1);
								end
								if (head.cmd.last) begin
									emit     = 1'b1;
									e_status = drop1 ? STATUS_OVF : STATUS_OK;
									inside_d = 1'b0;
									drop_d   = 1'b0;
								end else begin
									inside_d = 1'b1;
									drop_d   = drop1;
								end
							end
						end
						OP_GET: begin
							if (SIZE_W'(head.cmd.len) > SIZE_W'(used_q)) begin
								if (can_emit) begin
									pop      = 1'b1;
									emit     = 1'b1;
									e_status = STATUS_UNF;
									e_get    = 1'b1;
								end
							end else begin
								pop     = 1'b1;
								rem_d   = REM_W'(head.cmd.len);
								state_d = ST_STREAM;
							end
						end
						OP_GET_ERR: begin
							if (can_emit) begin
								pop      = 1'b1;
								emit     = 1'b1;
								e_status = STATUS_UNF;
								e_get    = 1'b1;
							end
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			ST_STREAM: begin
				if (can_emit) begin
					rd_en     = 1'b1;
					emit      = 1'b1;
					emit_data = 1'b1;
					e_get     = 1'b1;
					e_last    = (rem_q == REM_W'(1));
					e_free    = free + SIZE_W'(1);
					rd_d      = (rd_inc == ctrl.size) ? '0 : IDX_W'(rd_inc);
					used_d    = used_q - 1'b1;
					rem_d     = rem_q - 1'b1;
					if (rem_q == REM_W'(1)) begin
						state_d = ST_CMD;
					end
				end
			end
			default: begin
				state_d = ST_CMD;
			end
		endcase
		// a size write empties the ring and abandons any open chunk
		if (ctrl.clear) begin
			state_d  = ST_CMD;
			wr_d     = '0;
			rd_d     = '0;
			used_d   = '0;
			inside_d = 1'b0;
			drop_d   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byte_store_q[wr_q] <= head.cmd.data;
		end
		if (rd_en) begin
			rdata_q <= byte_store_q[rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q   <= emit_data;
			out_status_q <= e_status;
			out_get_q    <= e_get;
			out_last_q   <= e_last;
			out_free_q   <= FREE_W'(e_free);
			out_ovf_q    <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CMD;
			wr_q        <= '0;
			rd_q        <= '0;
			used_q      <= '0;
			inside_q    <= 1'b0;
			drop_q      <= 1'b0;
			ovf_q       <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			wr_q     <= wr_d;
			rd_q     <= rd_d;
			used_q   <= used_d;
			inside_q <= inside_d;
			drop_q   <= drop_d;
			ovf_q    <= ovf_d;
			rem_q    <= rem_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign data_out        = out_data_q ? rdata_q : 8'd0;
	assign status          = out_status_q;
	assign answers_get     = out_get_q;
	assign last            = out_last_q;
	assign free_space      = out_free_q;
	assign overflow_sticky = out_ovf_q;

endmodule

FILE: rtl/cbrb_checker.sv
// Port-level checker for the chunked byte ring buffer, bound to the top level.
// Depends on cbrb_pkg and chunked_byte_ring_buffer_unit_defines.svh.
`include "chunked_byte_ring_buffer_unit_defines.svh"

module cbrb_checker
	import cbrb_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [7:0]        data_out,
	input logic [1:0]        status,
	input logic              answers_get,
	input logic              last,
	input logic [FREE_W-1:0] free_space,
	input logic              overflow_sticky
);

	`CBRB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(data_out) && $stable(status) && $stable(free_space), "result item changed while stalled")
	`CBRB_ASSERT_NOW(a_unf_shape, clk, arst_n, out_valid && (status == STATUS_UNF), answers_get && last && (data_out == 8'd0), "underflow result malformed")
	`CBRB_ASSERT_NOW(a_put_shape, clk, arst_n, out_valid && !answers_get, last && (status != STATUS_UNF) && (data_out == 8'd0), "put result malformed")
	`CBRB_ASSERT_NOW(a_ovf_sticky, clk, arst_n, out_valid && (status == STATUS_OVF), overflow_sticky && !answers_get, "overflow without sticky flag")

endmodule

bind chunked_byte_ring_buffer_unit cbrb_checker u_cbrb_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.data_out        (data_out),
	.status          (status),
	.answers_get     (answers_get),
	.last            (last),
	.free_space      (free_space),
	.overflow_sticky (overflow_sticky)
);
